/* rtl/trie_lcp_pkg.sv */
// ----------------------------------------------------------------------------
// trie_lcp_pkg
// shared sizes, codes and types of the trie append and common prefix query
// ----------------------------------------------------------------------------
`default_nettype none

package trie_lcp_pkg;

	localparam int MAX_STRINGS = 1024;
	localparam int MAX_NODES   = 1024;
	localparam int ALPHABET    = 26;

	localparam int FIELD_W = 10;
	localparam int LET_W   = 5;
	localparam int STAT_W  = 2;

	localparam int STR_W       = $clog2(MAX_STRINGS);
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int SCNT_W      = $clog2(MAX_STRINGS + 1);
	localparam int NCNT_W      = $clog2(MAX_NODES + 1);
	localparam int SLOT_DEPTH  = MAX_NODES * ALPHABET;
	localparam int SLOT_W      = $clog2(SLOT_DEPTH);
	localparam int ACNT_W      = $clog2(ALPHABET);

	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNDEF = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic [NODE_W-1:0] depth;
	} node_info_t;

endpackage

`default_nettype wire

/* rtl/trie_lcp_ram.sv */
// ----------------------------------------------------------------------------
// trie_lcp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module trie_lcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/trie_append_lcp_query.sv */
// ----------------------------------------------------------------------------
// trie_append_lcp_query
// trie of lowercase strings in tables; append a letter to a string, or give
// the common prefix length of two strings by walking parents to their meeting
// ----------------------------------------------------------------------------
// a rejected word gives its result in the cycle after it is taken; an append
// to an existing child gives its result once the child's depth is read; an
// append that allocates a node gives its result, then stays busy while the
// new node's child row is cleared; a query reads info once per parent step
// one word at a time: busy stays high while a word's work goes on
// reset: a pass clears the root's child row, busy meanwhile
// the receiver cannot stall: done marks each result for one cycle
`default_nettype none

module trie_append_lcp_query import trie_lcp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [FIELD_W-1:0] first_string,
	input  wire logic [LET_W-1:0]   letter,
	input  wire logic [FIELD_W-1:0] second_string,
	output logic                    done,
	output logic      [FIELD_W-1:0] prefix_length,
	output logic      [FIELD_W-1:0] new_string,
	output logic      [STAT_W-1:0]  status
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_A_NOS,
		S_A_BASE,
		S_A_CHILD,
		S_A_CHK,
		S_A_CDEP,
		S_A_FIN,
		S_Q_RDA,
		S_Q_RDB,
		S_Q_INFA,
		S_Q_INFB,
		S_Q_DEPB,
		S_WALK,
		S_STEP
	} state_t;

	state_t state_q;

	logic [SCNT_W-1:0]  strings_used_q;
	logic [NCNT_W-1:0]  nodes_used_q;
	logic               init_q;
	logic [SLOT_W-1:0]  clr_addr_q;
	logic [ACNT_W-1:0]  clr_cnt_q;

	logic [STR_W-1:0]   s1_q;
	logic [STR_W-1:0]   s2_q;
	logic [LET_W-1:0]   letter_q;
	logic [NODE_W-1:0]  base_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [NODE_W-1:0]  child_q;
	logic [NODE_W-1:0]  a_q;
	logic [NODE_W-1:0]  b_q;
	logic [NODE_W-1:0]  da_q;
	logic [NODE_W-1:0]  db_q;
	logic               sel_a_q;

	logic               done_q;
	logic [FIELD_W-1:0] prefix_length_q;
	logic [FIELD_W-1:0] new_string_q;
	logic [STAT_W-1:0]  status_q;

	// ram ports
	logic               child_we;
	logic [SLOT_W-1:0]  child_waddr;
	logic [NODE_W-1:0]  child_wdata;
	logic [SLOT_W-1:0]  child_raddr;
	logic [NODE_W-1:0]  child_rd;

	logic               info_we;
	logic [NODE_W-1:0]  info_waddr;
	node_info_t         info_wdata;
	logic [NODE_W-1:0]  info_raddr;
	node_info_t         info_rd;

	logic               nos_we;
	logic [STR_W-1:0]   nos_waddr;
	logic [NODE_W-1:0]  nos_wdata;
	logic [STR_W-1:0]   nos_raddr;
	logic [NODE_W-1:0]  nos_rd;

	logic               accept;
	logic               s1_undef;
	logic               s2_undef;
	logic               let_bad;
	logic               str_full;
	logic               node_full;
	logic [NODE_W-1:0]  new_depth;

	assign accept    = start && (state_q == S_IDLE);
	assign s1_undef  = SCNT_W'(first_string) >= strings_used_q;
	assign s2_undef  = SCNT_W'(second_string) >= strings_used_q;
	assign let_bad   = 32'(letter) >= ALPHABET;
	assign str_full  = strings_used_q >= SCNT_W'(MAX_STRINGS);
	assign node_full = nodes_used_q >= NCNT_W'(MAX_NODES);
	assign new_depth = info_rd.depth + NODE_W'(1);

	trie_lcp_ram #(.WIDTH(NODE_W), .DEPTH(SLOT_DEPTH)) u_child (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (child_raddr),
		.rdata (child_rd)
	);

	trie_lcp_ram #(.WIDTH($bits(node_info_t)), .DEPTH(MAX_NODES)) u_info (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (info_wdata),
		.raddr (info_raddr),
		.rdata (info_rd)
	);

	trie_lcp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_STRINGS)) u_nos (
		.clk   (clk),
		.we    (nos_we),
		.waddr (nos_waddr),
		.wdata (nos_wdata),
		.raddr (nos_raddr),
		.rdata (nos_rd)
	);

	always_comb begin
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = '0;
		child_raddr = slot_q;
		info_we     = 1'b0;
		info_waddr  = NODE_W'(nodes_used_q);
		info_wdata  = '{parent: base_q, depth: new_depth};
		info_raddr  = base_q;
		nos_we      = 1'b0;
		nos_waddr   = STR_W'(strings_used_q);
		nos_wdata   = child_q;
		nos_raddr   = s1_q;
		case (state_q)
			S_CLR: begin
				child_we    = 1'b1;
				child_waddr = clr_addr_q;
				child_wdata = '0;
				// root entries of the node and string tables
				info_we     = init_q;
				info_waddr  = '0;
				info_wdata  = '0;
				nos_we      = init_q;
				nos_waddr   = '0;
				nos_wdata   = '0;
			end
			S_A_NOS: begin
				nos_raddr = s1_q;
			end
			S_A_CHILD: begin
				child_raddr = slot_q;
				info_raddr  = base_q;
			end
			S_A_CHK: begin
				if ((child_rd == '0) && !node_full) begin
					child_we    = 1'b1;
					child_waddr = slot_q;
					child_wdata = NODE_W'(nodes_used_q);
					info_we     = 1'b1;
					nos_we      = 1'b1;
					nos_wdata   = NODE_W'(nodes_used_q);
				end
			end
			S_A_CDEP: begin
				info_raddr = child_q;
			end
			S_A_FIN: begin
				nos_we    = 1'b1;
				nos_wdata = child_q;
			end
			S_Q_RDA: begin
				nos_raddr = s1_q;
			end
			S_Q_RDB: begin
				nos_raddr = s2_q;
			end
			S_Q_INFA: begin
				info_raddr = a_q;
			end
			S_Q_INFB: begin
				info_raddr = b_q;
			end
			S_WALK: begin
				info_raddr = (da_q >= db_q) ? a_q : b_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			strings_used_q <= SCNT_W'(1);
			nodes_used_q   <= NCNT_W'(1);
			init_q         <= 1'b1;
			clr_addr_q     <= '0;
			clr_cnt_q      <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + SLOT_W'(1);
					clr_cnt_q  <= clr_cnt_q + ACNT_W'(1);
					if (clr_cnt_q == ACNT_W'(ALPHABET - 1)) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						s1_q     <= STR_W'(first_string);
						s2_q     <= STR_W'(second_string);
						letter_q <= letter;
						if (action == ACT_QUERY) begin
							if (s1_undef || s2_undef) begin
								done_q          <= 1'b1;
								prefix_length_q <= '0;
								new_string_q    <= '0;
								status_q        <= ST_UNDEF;
							end else begin
								state_q <= S_Q_RDA;
							end
						end else begin
							if (s1_undef || let_bad) begin
								done_q          <= 1'b1;
								prefix_length_q <= '0;
								new_string_q    <= '0;
								status_q        <= ST_UNDEF;
							end else if (str_full) begin
								done_q          <= 1'b1;
								prefix_length_q <= '0;
								new_string_q    <= '0;
								status_q        <= ST_FULL;
							end else begin
								state_q <= S_A_NOS;
							end
						end
					end
				end
				S_A_NOS: begin
					state_q <= S_A_BASE;
				end
				S_A_BASE: begin
					base_q  <= nos_rd;
					slot_q  <= SLOT_W'(nos_rd) * SLOT_W'(ALPHABET) + SLOT_W'(letter_q);
					state_q <= S_A_CHILD;
				end
				S_A_CHILD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					child_q <= child_rd;
					if (child_rd != '0) begin
						state_q <= S_A_CDEP;
					end else if (node_full) begin
						done_q          <= 1'b1;
						prefix_length_q <= '0;
						new_string_q    <= '0;
						status_q        <= ST_FULL;
						state_q         <= S_IDLE;
					end else begin
						// new node, its child row is cleared next
						done_q          <= 1'b1;
						prefix_length_q <= FIELD_W'(new_depth);
						new_string_q    <= FIELD_W'(strings_used_q);
						status_q        <= ST_OK;
						strings_used_q  <= strings_used_q + SCNT_W'(1);
						nodes_used_q    <= nodes_used_q + NCNT_W'(1);
						clr_addr_q      <= SLOT_W'(nodes_used_q) * SLOT_W'(ALPHABET);
						clr_cnt_q       <= '0;
						state_q         <= S_CLR;
					end
				end
				S_A_CDEP: begin
					state_q <= S_A_FIN;
				end
				S_A_FIN: begin
					done_q          <= 1'b1;
					prefix_length_q <= FIELD_W'(info_rd.depth);
					new_string_q    <= FIELD_W'(strings_used_q);
					status_q        <= ST_OK;
					strings_used_q  <= strings_used_q + SCNT_W'(1);
					state_q         <= S_IDLE;
				end
				S_Q_RDA: begin
					state_q <= S_Q_RDB;
				end
				S_Q_RDB: begin
					a_q     <= nos_rd;
					state_q <= S_Q_INFA;
				end
				S_Q_INFA: begin
					b_q     <= nos_rd;
					state_q <= S_Q_INFB;
				end
				S_Q_INFB: begin
					da_q    <= info_rd.depth;
					state_q <= S_Q_DEPB;
				end
				S_Q_DEPB: begin
					db_q    <= info_rd.depth;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (a_q == b_q) begin
						done_q          <= 1'b1;
						prefix_length_q <= FIELD_W'(da_q);
						new_string_q    <= '0;
						status_q        <= ST_OK;
						state_q         <= S_IDLE;
					end else begin
						// lift the deeper node, or the first one at equal depth
						sel_a_q <= (da_q >= db_q);
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (sel_a_q) begin
						a_q  <= info_rd.parent;
						da_q <= da_q - NODE_W'(1);
					end else begin
						b_q  <= info_rd.parent;
						db_q <= db_q - NODE_W'(1);
					end
					state_q <= S_WALK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign prefix_length = prefix_length_q;
	assign new_string    = new_string_q;
	assign status        = status_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks trie_append_lcp_query: a directed table of appends and queries, a
// random mix of well-formed and broken words, then a short tail of edge
// words; each result is compared with a table value or with an in-bench trie that
// lifts the deeper node, then both together; random words run under sender gaps of several densities
// ----------------------------------------------------------------------------

module tb_top;
	import trie_lcp_pkg::*;

	localparam int RANDOM_WORDS = 520;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic               act;
		logic [FIELD_W-1:0] s1;
		logic [LET_W-1:0]   ltr;
		logic [FIELD_W-1:0] s2;
		bit                 known;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] nstr;
		logic [STAT_W-1:0]  st;
	} word_row_t;

	typedef struct {
		logic [FIELD_W-1:0] prefix_length;
		logic [FIELD_W-1:0] new_string;
		logic [STAT_W-1:0]  status;
	} lcp_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [FIELD_W-1:0] first_string;
	logic [LET_W-1:0]   letter;
	logic [FIELD_W-1:0] second_string;
	logic               done;
	logic [FIELD_W-1:0] prefix_length;
	logic [FIELD_W-1:0] new_string;
	logic [STAT_W-1:0]  status;

	// in-bench copy of the trie
	int trie_child [SLOT_DEPTH];
	int trie_parent [MAX_NODES];
	int trie_depth [MAX_NODES];
	int string_node [MAX_STRINGS];
	int string_count = 1;
	int node_count = 1;

	lcp_result_t pending_results[$];
	int fail_count = 0;
	int stall_cycles = 0;
	int idle_pct = 0;

	word_row_t directed_rows [23];

	trie_append_lcp_query dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.first_string(first_string),
		.letter(letter),
		.second_string(second_string),
		.done(done),
		.prefix_length(prefix_length),
		.new_string(new_string),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic lcp_result_t predict_word(input word_row_t w);
		lcp_result_t r;
		int a;
		int b;
		int base;
		int slot;
		int child;
		r.prefix_length = '0;
		r.new_string = '0;
		r.status = ST_OK;
		if (w.act == ACT_QUERY) begin
			if (w.s1 >= string_count || w.s2 >= string_count) begin
				r.status = ST_UNDEF;
				return r;
			end
			a = string_node[w.s1];
			b = string_node[w.s2];
			while (trie_depth[a] > trie_depth[b])
				a = trie_parent[a];
			while (trie_depth[b] > trie_depth[a])
				b = trie_parent[b];
			while (a != b) begin
				a = trie_parent[a];
				b = trie_parent[b];
			end
			r.prefix_length = FIELD_W'(trie_depth[a]);
			return r;
		end
		if (w.s1 >= string_count || w.ltr >= ALPHABET) begin
			r.status = ST_UNDEF;
			return r;
		end
		if (string_count >= MAX_STRINGS) begin
			r.status = ST_FULL;
			return r;
		end
		base = string_node[w.s1];
		slot = base * ALPHABET + w.ltr;
		child = trie_child[slot];
		if (child == 0) begin
			if (node_count >= MAX_NODES) begin
				r.status = ST_FULL;
				return r;
			end
			child = node_count;
			node_count++;
			trie_child[slot] = child;
			trie_parent[child] = base;
			trie_depth[child] = trie_depth[base] + 1;
		end
		string_node[string_count] = child;
		r.new_string = FIELD_W'(string_count);
		r.prefix_length = FIELD_W'(trie_depth[child]);
		string_count++;
		return r;
	endfunction

	task automatic drive_word(input word_row_t w);
		lcp_result_t r;
		start <= 1'b1;
		action <= w.act;
		first_string <= w.s1;
		letter <= w.ltr;
		second_string <= w.s2;
		do
			@(posedge clk);
		while (busy);
		r = predict_word(w);
		if (w.known) begin
			r.prefix_length = w.len;
			r.new_string = w.nstr;
			r.status = w.st;
		end
		pending_results.push_back(r);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic word_row_t random_word();
		word_row_t w;
		int r;
		w.known = 1'b0;
		w.len = '0;
		w.nstr = '0;
		w.st = ST_OK;
		w.s2 = FIELD_W'($urandom_range(0, 1023));
		w.ltr = LET_W'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			w.act = ACT_APPEND;
			r = $urandom_range(0, 99);
			if (r < 60)
				w.s1 = FIELD_W'($urandom_range(0, string_count - 1));
			else if (r < 85)
				w.s1 = FIELD_W'(string_count - 1);
			else
				w.s1 = FIELD_W'($urandom_range(0, 1023));
			r = $urandom_range(0, 99);
			if (r < 45)
				w.ltr = LET_W'($urandom_range(0, 3));
			else if (r < 90)
				w.ltr = LET_W'($urandom_range(0, ALPHABET - 1));
		end else begin
			w.act = ACT_QUERY;
			if ($urandom_range(0, 99) < 85) begin
				w.s1 = FIELD_W'($urandom_range(0, string_count - 1));
				w.s2 = FIELD_W'($urandom_range(0, string_count - 1));
			end else begin
				w.s1 = FIELD_W'($urandom_range(0, 1023));
			end
		end
		return w;
	endfunction

	function automatic word_row_t fill_word(input int n);
		word_row_t w;
		w.known = 1'b0;
		w.len = '0;
		w.nstr = '0;
		w.st = ST_OK;
		w.ltr = LET_W'($urandom_range(0, ALPHABET - 1));
		w.s2 = FIELD_W'($urandom_range(0, 1023));
		if (n % 60 == 59) begin
			w.act = ACT_QUERY;
			w.s1 = FIELD_W'(string_count - 1);
			w.s2 = FIELD_W'($urandom_range(0, string_count - 1));
		end else begin
			w.act = ACT_APPEND;
			if ($urandom_range(0, 1) == 0)
				w.s1 = FIELD_W'(string_count - 1);
			else
				w.s1 = FIELD_W'($urandom_range(0, string_count - 1));
		end
		return w;
	endfunction

	// result checking
	always @(posedge clk) begin : check_results
		lcp_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("word with no expectation: prefix_length %0d new_string %0d status %0d",
					prefix_length, new_string, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (prefix_length !== want.prefix_length) begin
					$error("prefix_length: expected %0d, got %0d", want.prefix_length,
						prefix_length);
					fail_count++;
				end
				if (new_string !== want.new_string) begin
					$error("new_string: expected %0d, got %0d", want.new_string, new_string);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** trie_append_lcp_query: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		word_row_t w;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_APPEND;
		first_string <= '0;
		letter <= '0;
		second_string <= '0;
		directed_rows = '{
			'{ACT_QUERY,  0,    0,  0,    1, 0, 0, ST_OK},
			'{ACT_QUERY,  0,    31, 1,    1, 0, 0, ST_UNDEF},
			'{ACT_QUERY,  1023, 0,  0,    1, 0, 0, ST_UNDEF},
			'{ACT_APPEND, 1,    0,  0,    1, 0, 0, ST_UNDEF},
			'{ACT_APPEND, 0,    26, 0,    1, 0, 0, ST_UNDEF},
			'{ACT_APPEND, 0,    31, 1023, 1, 0, 0, ST_UNDEF},
			'{ACT_APPEND, 0,    0,  0,    1, 1, 1, ST_OK},
			'{ACT_APPEND, 0,    0,  1023, 1, 1, 2, ST_OK},
			'{ACT_APPEND, 1,    25, 0,    1, 2, 3, ST_OK},
			'{ACT_APPEND, 3,    12, 1023, 1, 3, 4, ST_OK},
			'{ACT_QUERY,  4,    0,  2,    0, 0, 0, ST_OK},
			'{ACT_QUERY,  3,    0,  4,    0, 0, 0, ST_OK},
			'{ACT_QUERY,  4,    31, 4,    1, 3, 0, ST_OK},
			'{ACT_APPEND, 0,    25, 0,    1, 1, 5, ST_OK},
			'{ACT_QUERY,  5,    0,  4,    1, 0, 0, ST_OK},
			'{ACT_QUERY,  4,    0,  5,    0, 0, 0, ST_OK},
			'{ACT_QUERY,  1,    0,  2,    0, 0, 0, ST_OK},
			'{ACT_APPEND, 2,    0,  0,    0, 0, 0, ST_OK},
			'{ACT_QUERY,  6,    0,  3,    0, 0, 0, ST_OK},
			'{ACT_APPEND, 1023, 0,  0,    1, 0, 0, ST_UNDEF},
			'{ACT_QUERY,  7,    0,  0,    1, 0, 0, ST_UNDEF},
			'{ACT_QUERY,  0,    0,  6,    0, 0, 0, ST_OK},
			'{ACT_APPEND, 6,    31, 0,    1, 0, 0, ST_UNDEF}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed_rows); i++)
			drive_word(directed_rows[i]);
		wait_results_drained();
		@(posedge clk);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			case ((i / 70) % 4)
				0: idle_pct = 0;
				1: idle_pct = 48;
				2: idle_pct = 0;
				default: idle_pct = 33;
			endcase
			if (i == RANDOM_WORDS / 2) begin
				wait_results_drained();
				@(posedge clk);
			end
			drive_word(random_word());
		end

		idle_pct = 0;
		for (i = 0; i < 8; i++) begin
			w = fill_word(0);
			case (i)
				0: w.s1 = 0;
				1: w.ltr = LET_W'($urandom_range(ALPHABET, 31));
				2: begin
					w.act = ACT_QUERY;
					w.s1 = FIELD_W'(MAX_STRINGS - 1);
					w.s2 = FIELD_W'(MAX_STRINGS - 1);
				end
				3: begin
					w.act = ACT_QUERY;
					w.s1 = FIELD_W'(MAX_STRINGS - 1);
					w.s2 = 0;
				end
				4: begin
					w.act = ACT_QUERY;
					w.s1 = FIELD_W'($urandom_range(0, 1023));
					w.s2 = FIELD_W'(MAX_STRINGS - 1);
				end
				default: ;
			endcase
			drive_word(w);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** trie_append_lcp_query: PASSED **");
		else
			$display("** trie_append_lcp_query: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
rtl/trie_lcp_pkg.sv
rtl/trie_lcp_ram.sv
rtl/trie_append_lcp_query.sv
tb/sv/tb_top.sv
